FILE: rtl/pamt_pkg.sv
// Shared types, constants and codes of the PWM angle multi-turn tracker.
package pamt_pkg;

   // Default number of angle steps in one turn.
   localparam int ANGLE_STEPS_DEF = 4096;

   // Field widths.
   localparam int US_W     = 24;
   localparam int FRAME_W  = 13;
   localparam int PRE_W    = 8;
   localparam int ZERO_W   = 12;
   localparam int RAW_W    = 12;
   localparam int COUNT_W  = 32;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // Divider widths: for high time <= period the quotient <= frame count.
   localparam int QUOT_W   = FRAME_W;
   localparam int NUM_W    = US_W + FRAME_W + 1;

   // Reset values of the configuration registers.
   localparam logic [US_W-1:0]    STALE_RST = 24'd50000;
   localparam logic               CW_RST    = 1'b0;
   localparam logic [FRAME_W-1:0] FRAME_RST = 13'd4351;
   localparam logic [PRE_W-1:0]   PRE_RST   = 8'd128;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_STALE_LIMIT = 2'd0,
      REG_CW_NEGATE   = 2'd1,
      REG_FRAME       = 2'd2,
      REG_PREAMBLE    = 2'd3
   } reg_idx_type;

   // Item operations.
   typedef enum logic {
      OP_UPDATE   = 1'b0,
      OP_SET_ZERO = 1'b1
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ANGLE,
      ST_UPDATE
   } state_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [US_W-1:0]    stale_limit_us;
      logic               clockwise_negate;
      logic [FRAME_W-1:0] frame_len;
      logic [PRE_W-1:0]   preamble_counts;
   } cfg_type;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic start;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_rsp_type;

endpackage

FILE: rtl/pamt_csr.sv
// Configuration register file of the tracker with its APB-style access port.
module pamt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pamt_pkg::ADDR_W-1:0] paddr,
   input  logic [pamt_pkg::DATA_W-1:0] pwdata,
   output logic [pamt_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output pamt_pkg::cfg_type           cfg
);

   pamt_pkg::cfg_type     cfg_ff;
   pamt_pkg::cfg_type     cfg_in;
   pamt_pkg::reg_idx_type idx;
   logic                  wr_en;

   assign pready = 1'b1;
   assign idx    = pamt_pkg::reg_idx_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;

   // Register writes reach cfg at the clock edge that ends the access cycle.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            pamt_pkg::REG_STALE_LIMIT: cfg_in.stale_limit_us   = pwdata[pamt_pkg::US_W-1:0];
            pamt_pkg::REG_CW_NEGATE:   cfg_in.clockwise_negate = pwdata[0];
            pamt_pkg::REG_FRAME:       cfg_in.frame_len        = pwdata[pamt_pkg::FRAME_W-1:0];
            pamt_pkg::REG_PREAMBLE:    cfg_in.preamble_counts  = pwdata[pamt_pkg::PRE_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stale_limit_us   <= pamt_pkg::STALE_RST;
         cfg_ff.clockwise_negate <= pamt_pkg::CW_RST;
         cfg_ff.frame_len        <= pamt_pkg::FRAME_RST;
         cfg_ff.preamble_counts  <= pamt_pkg::PRE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register, zero-extended.
   always_comb begin
      case (idx)
         pamt_pkg::REG_STALE_LIMIT: prdata = pamt_pkg::DATA_W'(cfg_ff.stale_limit_us);
         pamt_pkg::REG_CW_NEGATE:   prdata = pamt_pkg::DATA_W'(cfg_ff.clockwise_negate);
         pamt_pkg::REG_FRAME:       prdata = pamt_pkg::DATA_W'(cfg_ff.frame_len);
         pamt_pkg::REG_PREAMBLE:    prdata = pamt_pkg::DATA_W'(cfg_ff.preamble_counts);
         default:                   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/pamt_div.sv
// Shared restoring divider: one quotient bit per cycle by shift and subtract.
module pamt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  pamt_pkg::div_req_type       req,
   input  logic [pamt_pkg::NUM_W-1:0]  num,
   input  logic [pamt_pkg::US_W-1:0]   den,
   output pamt_pkg::div_rsp_type       rsp,
   output logic [pamt_pkg::QUOT_W-1:0] quot
);

   localparam int QW = pamt_pkg::QUOT_W;
   localparam int RW = pamt_pkg::NUM_W - QW;
   localparam int CW = $clog2(QW + 1);

   logic [RW-1:0] rem_ff,   rem_in;
   logic [QW-1:0] numlo_ff, numlo_in;
   logic [QW-1:0] quot_ff,  quot_in;
   logic [CW-1:0] cnt_ff,   cnt_in;
   logic          busy_ff,  busy_in;
   logic          done_ff,  done_in;
   logic [RW:0]   rem_sh;
   logic [RW+1:0] diff;
   logic          fits;

   // One trial subtraction of the divisor from the shifted partial remainder.
   assign rem_sh = {rem_ff, numlo_ff[QW-1]};
   assign diff   = {1'b0, rem_sh} - (RW+2)'(den);
   assign fits   = !diff[RW+1];

   always_comb begin
      rem_in   = rem_ff;
      numlo_in = numlo_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = num[pamt_pkg::NUM_W-1:QW];
         numlo_in = num[QW-1:0];
         cnt_in   = CW'(QW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[RW-1:0] : rem_sh[RW-1:0];
         numlo_in = {numlo_ff[QW-2:0], 1'b0};
         quot_in  = {quot_ff[QW-2:0], fits};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      numlo_ff <= numlo_in;
      quot_ff  <= quot_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign quot     = quot_ff;

endmodule

FILE: rtl/pwm_angle_multiturn_tracker.sv
// Top level of the PWM angle decoder with multi-turn position tracking.
//
//   Port group    Direction  Handshake            Moves
//   req_*         in         req_valid/req_ready  one PWM sample or set-zero item
//   rsp_*         out        rsp_valid/rsp_ready  one position result item
//   APB (p*)      in/out     psel/penable/pready  configuration register access
//
// An item passes through these steps from acceptance to result: form the scaled
// duty product and load it into the shared shift-subtract divider, 13 divider steps
// and a check that they are done, then angle decode and then the update step.
// req_ready is high only while the sequencer is idle, so one item is in work at a
// time and a new item is taken only once the last has left the update step.
// A waiting result sits in the output register, so the next item can be taken;
// the update step holds until that register is free.
// Reset is synchronous and restores the configuration defaults and tracking state.
module pwm_angle_multiturn_tracker #(
   parameter int ANGLE_STEPS = pamt_pkg::ANGLE_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [pamt_pkg::US_W-1:0]           req_high_us,
   input  logic [pamt_pkg::US_W-1:0]           req_period_us,
   input  logic [pamt_pkg::US_W-1:0]           req_sample_age_us,
   input  logic [pamt_pkg::ZERO_W-1:0]         req_zero_angle,
   // Result items.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pamt_pkg::COUNT_W-1:0] rsp_position_count,
   output logic [pamt_pkg::RAW_W-1:0]          rsp_angle_raw,
   output logic                                rsp_status,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pamt_pkg::ADDR_W-1:0]         paddr,
   input  logic [pamt_pkg::DATA_W-1:0]         pwdata,
   output logic [pamt_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int AW  = $clog2(ANGLE_STEPS);
   localparam int EW  = 17;
   localparam int DW  = AW + 2;
   localparam int CNW = pamt_pkg::COUNT_W;
   localparam logic [EW-1:0]        ANG_MAX = EW'(ANGLE_STEPS - 1);
   localparam logic signed [DW-1:0] STEPS_S = DW'(ANGLE_STEPS);
   localparam logic signed [DW-1:0] HALF_S  = DW'(ANGLE_STEPS / 2);

   pamt_pkg::cfg_type     cfg;
   pamt_pkg::div_req_type div_req;
   pamt_pkg::div_rsp_type div_rsp;
   pamt_pkg::state_type   state_ff, state_in;

   logic [pamt_pkg::NUM_W-1:0]  div_num;
   logic [pamt_pkg::NUM_W-2:0]  prod;
   logic [pamt_pkg::QUOT_W-1:0] quot;

   // Captured item.
   logic                         op_ff;
   logic [pamt_pkg::US_W-1:0]    hi_ff, per_ff, age_ff;
   logic [pamt_pkg::ZERO_W-1:0]  za_ff;

   // Decoded angle of the item.
   logic [AW-1:0] ang_ff, ang_in;
   logic          good_ff, good_in;

   // Tracking state.
   logic [AW-1:0]  last_ff, last_in;
   logic [CNW-1:0] cum_ff,  cum_in;
   logic           have_ff, have_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNW-1:0]       out_count_ff, out_count_in;
   logic [pamt_pkg::RAW_W-1:0] out_raw_ff, out_raw_in;
   logic                 out_status_ff, out_status_in;

   logic                      accept;
   logic                      slot_free;
   logic [pamt_pkg::QUOT_W-1:0] pre_ext;
   logic [pamt_pkg::QUOT_W-1:0] above;
   logic [EW-1:0]             above_ext;
   logic [EW-1:0]             za_ext;
   logic [EW-1:0]             ang_ext;
   logic [AW-1:0]             za_clamp;
   logic signed [DW-1:0]      diff_raw;
   logic signed [DW-1:0]      diff;
   logic [CNW-1:0]            diff_ext;
   logic                      stale;

   pamt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Rounded dividend: high time times frame counts plus half the period.
   assign prod    = hi_ff * cfg.frame_len;
   assign div_num = {1'b0, prod} + pamt_pkg::NUM_W'(per_ff[pamt_pkg::US_W-1:1]);
   assign div_req.start = (state_ff == pamt_pkg::ST_MUL);

   pamt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .num   (div_num),
      .den   (per_ff),
      .rsp   (div_rsp),
      .quot  (quot)
   );

   assign req_ready = (state_ff == pamt_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Angle decode: subtract the preamble, floor at zero, clamp to the top step.
   assign pre_ext   = pamt_pkg::QUOT_W'(cfg.preamble_counts);
   assign above     = quot - pre_ext;
   assign above_ext = EW'(above);

   always_comb begin
      good_in = good_ff;
      ang_in  = ang_ff;
      if (state_ff == pamt_pkg::ST_ANGLE) begin
         good_in = (per_ff != '0) && (hi_ff <= per_ff);
         if (!good_in || (quot <= pre_ext)) begin
            ang_in = '0;
         end else if (above_ext > ANG_MAX) begin
            ang_in = AW'(ANG_MAX);
         end else begin
            ang_in = AW'(above_ext);
         end
      end
   end

   // Shortest-way difference from the last angle, sign-extended to the count.
   assign diff_raw = $signed(DW'(ang_ff)) - $signed(DW'(last_ff));
   always_comb begin
      if (diff_raw > HALF_S) begin
         diff = diff_raw - STEPS_S;
      end else if (diff_raw < -HALF_S) begin
         diff = diff_raw + STEPS_S;
      end else begin
         diff = diff_raw;
      end
   end
   assign diff_ext = {{(CNW-DW){diff[DW-1]}}, diff};

   assign za_ext   = EW'(za_ff);
   assign za_clamp = (za_ext > ANG_MAX) ? AW'(ANG_MAX) : AW'(za_ext);
   assign ang_ext  = EW'(ang_ff);
   assign stale    = age_ff > cfg.stale_limit_us;

   // Sequencer, tracking state update and output register.
   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      cum_in        = cum_ff;
      have_in       = have_ff;
      out_count_in  = out_count_ff;
      out_raw_in    = out_raw_ff;
      out_status_in = out_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         pamt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pamt_pkg::ST_MUL;
            end
         end
         pamt_pkg::ST_MUL: begin
            state_in = pamt_pkg::ST_DIV;
         end
         pamt_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = pamt_pkg::ST_ANGLE;
            end
         end
         pamt_pkg::ST_ANGLE: begin
            state_in = pamt_pkg::ST_UPDATE;
         end
         pamt_pkg::ST_UPDATE: begin
            if (slot_free) begin
               out_status_in = 1'b0;
               if (op_ff == pamt_pkg::OP_UPDATE) begin
                  if (!good_ff || stale) begin
                     out_status_in = 1'b1;
                  end else if (!have_ff) begin
                     last_in = ang_ff;
                     cum_in  = '0;
                     have_in = 1'b1;
                  end else begin
                     cum_in  = cfg.clockwise_negate ? (cum_ff - diff_ext)
                                                    : (cum_ff + diff_ext);
                     last_in = ang_ff;
                  end
               end else begin
                  if (za_ff != '0) begin
                     last_in = za_clamp;
                     cum_in  = '0;
                  end else if (!good_ff) begin
                     out_status_in = 1'b1;
                  end else begin
                     last_in = ang_ff;
                     cum_in  = '0;
                     have_in = 1'b1;
                  end
               end
               out_count_in = cum_in;
               out_raw_in   = ang_ext[pamt_pkg::RAW_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = pamt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pamt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pamt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         cum_ff       <= '0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         cum_ff       <= cum_in;
         have_ff      <= have_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         hi_ff  <= req_high_us;
         per_ff <= req_period_us;
         age_ff <= req_sample_age_us;
         za_ff  <= req_zero_angle;
      end
      good_ff       <= good_in;
      ang_ff        <= ang_in;
      out_count_ff  <= out_count_in;
      out_raw_ff    <= out_raw_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_count = $signed(out_count_ff);
   assign rsp_angle_raw      = out_raw_ff;
   assign rsp_status         = out_status_ff;

endmodule

FILE: rtl/pamt_checker.sv
// Port-level checks of the tracker and the bind that attaches them.
module pamt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [pamt_pkg::COUNT_W-1:0] rsp_position_count,
   input logic [pamt_pkg::RAW_W-1:0]          rsp_angle_raw,
   input logic                                rsp_status,
   input logic                                pready
);

   // One item at a time: after an acceptance the block is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an item was accepted");

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // A stalled result holds its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position_count)
         && $stable(rsp_angle_raw) && $stable(rsp_status))
      else $error("result changed while stalled");

   // The configuration port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind pwm_angle_multiturn_tracker pamt_checker u_pamt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_position_count (rsp_position_count),
   .rsp_angle_raw      (rsp_angle_raw),
   .rsp_status         (rsp_status),
   .pready             (pready)
);
